@@ src/affinv_pkg.sv @@
// Shared types and constants for the affine 3x4 matrix inverse block.
// No dependencies; used by the divider and the top level.
package affinv_pkg;
  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DEN_W         = 96;
  localparam int DIV_LAT       = DATA_W + 2;
  localparam int ROW_W         = 2;
  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;
endpackage

@@ src/affinv_div.sv @@
// Pipelined restoring divider with round to nearest and 32-bit saturation.
// Depends on affinv_pkg.
module affinv_div #(
  parameter int NUM_W = 112,
  parameter int DW    = 96
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [NUM_W-1:0]      num_mag,
  input  logic                  num_neg,
  input  logic [DW-1:0]         den_mag,
  output affinv_pkg::word_t     quo
);
  import affinv_pkg::*;

  localparam int QW = DATA_W;
  localparam int CW = (NUM_W > DW + QW) ? NUM_W : DW + QW;
  localparam logic [QW:0] LIM = (QW + 1)'(1) << (QW - 1);

  logic [NUM_W-1:0] rem  [0:QW];
  logic [DW-1:0]    den  [0:QW];
  logic [QW-1:0]    qb   [0:QW];
  logic             neg  [0:QW];
  logic             ovf  [0:QW];

  logic [NUM_W-1:0] rem_next [0:QW-1];
  logic [QW-1:0]    qb_next  [0:QW-1];
  logic             ovf0;
  logic             half;
  logic [QW:0]      q1;

  assign ovf0 = {1'b0, CW'(num_mag)} >= ({1'b0, CW'(den_mag)} << QW);

  always_comb begin
    logic [CW-1:0] dsh;
    logic [CW-1:0] rw;
    dsh = '0;
    rw  = '0;
    for (int k = 0; k < QW; k++) begin
      dsh = CW'(den[k]) << (QW - 1 - k);
      rw  = CW'(rem[k]);
      rem_next[k] = rem[k];
      qb_next[k]  = qb[k];
      if (rw >= dsh) begin
        rem_next[k] = NUM_W'(rw - dsh);
        qb_next[k][QW - 1 - k] = 1'b1;
      end
    end
  end

  assign half = {rem[QW][DW-1:0], 1'b0} >= {1'b0, den[QW]};
  assign q1   = {1'b0, qb[QW]} + (QW + 1)'(half);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_mag;
      den[0] <= den_mag;
      qb[0]  <= '0;
      neg[0] <= num_neg;
      ovf[0] <= ovf0;
      for (int k = 0; k < QW; k++) begin
        rem[k+1] <= rem_next[k];
        den[k+1] <= den[k];
        qb[k+1]  <= qb_next[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
      if (neg[QW]) begin
        if (ovf[QW] || q1 > LIM) begin
          quo <= {1'b1, {(QW-1){1'b0}}};
        end else begin
          quo <= QW'(-q1);
        end
      end else begin
        if (ovf[QW] || q1 > LIM - 1'b1) begin
          quo <= {1'b0, {(QW-1){1'b1}}};
        end else begin
          quo <= QW'(q1);
        end
      end
    end
  end
endmodule

@@ src/affine_matrix_inverse_top.sv @@
// Top level of the affine 3x4 matrix inverse, signed fixed point.
// Depends on affinv_pkg and affinv_div.
//
// One input item carries the three upper rows of an affine transform. The block
// answers with three result items, rows 0, 1 and 2 of the inverse, in order.
// Both channels use valid and stall; an item moves when valid is high and stall
// is low. The input item is held in a register and issued as three row jobs
// into a pipeline that takes one row per cycle while the output is not stalled:
// cofactor products, cofactor differences, partial products, term sums,
// determinant and translation sums, sign and magnitude, then a 34-stage divider
// that loads its operands, forms one quotient bit per stage, then rounds and
// saturates. A new item is taken while idle or as the last row job of the
// current one issues. A singular matrix gives all entries zero and singular set.
// While the receiver stalls a waiting result, the whole pipeline holds and
// nothing is lost or repeated. Reset clears the row counter and all valid
// bits; no result is pending afterwards.
module affine_matrix_inverse_top #(
  parameter int FRAC_BITS = affinv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  affinv_pkg::word_t           e00, e01, e02, tx,
  input  affinv_pkg::word_t           e10, e11, e12, ty,
  input  affinv_pkg::word_t           e20, e21, e22, tz,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [affinv_pkg::ROW_W-1:0] row_index,
  output affinv_pkg::word_t           col0, col1, col2, col3,
  output logic                        singular,
  output logic                        last_row
);
  import affinv_pkg::*;

  localparam int NUM_W = DEN_W + FRAC_BITS;

  logic adv;
  logic in_acc;

  word_t            hm [3][3];
  word_t            ht [3];
  logic             busy;
  logic [ROW_W-1:0] cnt;
  logic [ROW_W-1:0] r1, r2;

  logic             s1_v;
  logic [ROW_W-1:0] s1_row;
  logic signed [63:0] s1_pa [3], s1_pb [3], s1_pc [3], s1_pd [3];
  word_t            s1_m0 [3], s1_t [3];

  logic             s2_v;
  logic [ROW_W-1:0] s2_row;
  logic signed [63:0] s2_adjr [3], s2_adjc [3];
  word_t            s2_m0 [3], s2_t [3];

  logic             s3_v;
  logic [ROW_W-1:0] s3_row;
  logic signed [63:0] s3_adjr [3], s3_dhi [3], s3_ahi [3];
  logic signed [64:0] s3_dlo [3], s3_alo [3];

  logic             s4_v;
  logic [ROW_W-1:0] s4_row;
  logic signed [63:0] s4_adjr [3];
  logic signed [96:0] s4_dt [3], s4_at [3];

  logic             s5_v;
  logic [ROW_W-1:0] s5_row;
  logic signed [63:0] s5_adjr [3];
  logic signed [98:0] s5_det, s5_acc;

  logic             s6_v;
  logic [ROW_W-1:0] s6_row;
  logic             s6_sing;
  logic [NUM_W-1:0] s6_num [4];
  logic             s6_neg [4];
  logic [DEN_W-1:0] s6_den;

  logic             tv   [DIV_LAT];
  logic [ROW_W-1:0] trow [DIV_LAT];
  logic             tsg  [DIV_LAT];
  word_t            quo  [4];

  logic signed [98:0] det_abs, acc_abs;
  logic [63:0]        adj_abs [3];

  assign out_valid = tv[DIV_LAT-1];
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = busy && !(adv && cnt == ROW_LAST);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    unique case (cnt)
      ROW_FIRST: begin r1 = ROW_MID;   r2 = ROW_LAST;  end
      ROW_MID:   begin r1 = ROW_LAST;  r2 = ROW_FIRST; end
      ROW_LAST:  begin r1 = ROW_FIRST; r2 = ROW_MID;   end
      default:   begin r1 = ROW_MID;   r2 = ROW_LAST;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= ROW_FIRST;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
        cnt  <= ROW_FIRST;
      end else if (busy && adv) begin
        if (cnt == ROW_LAST) begin
          busy <= 1'b0;
          cnt  <= ROW_FIRST;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hm[0][0] <= e00; hm[0][1] <= e01; hm[0][2] <= e02; ht[0] <= tx;
      hm[1][0] <= e10; hm[1][1] <= e11; hm[1][2] <= e12; ht[1] <= ty;
      hm[2][0] <= e20; hm[2][1] <= e21; hm[2][2] <= e22; ht[2] <= tz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        tv[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_v <= busy;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      tv[0] <= s6_v;
      for (int i = 1; i < DIV_LAT; i++) begin
        tv[i] <= tv[i-1];
      end
    end
  end

  always_comb begin
    det_abs = s5_det[98] ? -s5_det : s5_det;
    acc_abs = s5_acc[98] ? -s5_acc : s5_acc;
    for (int c = 0; c < 3; c++) begin
      adj_abs[c] = s5_adjr[c][63] ? 64'(-s5_adjr[c]) : 64'(s5_adjr[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row <= cnt;
      for (int c = 0; c < 3; c++) begin
        s1_pa[c] <= hm[(c+1)%3][r1] * hm[(c+2)%3][r2];
        s1_pb[c] <= hm[(c+2)%3][r1] * hm[(c+1)%3][r2];
        s1_pc[c] <= hm[1][(c+1)%3] * hm[2][(c+2)%3];
        s1_pd[c] <= hm[2][(c+1)%3] * hm[1][(c+2)%3];
        s1_m0[c] <= hm[0][c];
        s1_t[c]  <= ht[c];
      end

      s2_row <= s1_row;
      for (int c = 0; c < 3; c++) begin
        s2_adjr[c] <= s1_pa[c] - s1_pb[c];
        s2_adjc[c] <= s1_pc[c] - s1_pd[c];
        s2_m0[c]   <= s1_m0[c];
        s2_t[c]    <= s1_t[c];
      end

      s3_row <= s2_row;
      for (int c = 0; c < 3; c++) begin
        s3_adjr[c] <= s2_adjr[c];
        s3_dhi[c]  <= s2_m0[c] * $signed(s2_adjc[c][63:32]);
        s3_dlo[c]  <= s2_m0[c] * $signed({1'b0, s2_adjc[c][31:0]});
        s3_ahi[c]  <= s2_t[c] * $signed(s2_adjr[c][63:32]);
        s3_alo[c]  <= s2_t[c] * $signed({1'b0, s2_adjr[c][31:0]});
      end

      s4_row <= s3_row;
      for (int c = 0; c < 3; c++) begin
        s4_adjr[c] <= s3_adjr[c];
        s4_dt[c]   <= (97'(s3_dhi[c]) <<< 32) + 97'(s3_dlo[c]);
        s4_at[c]   <= (97'(s3_ahi[c]) <<< 32) + 97'(s3_alo[c]);
      end

      s5_row <= s4_row;
      s5_adjr <= s4_adjr;
      s5_det <= 99'(s4_dt[0]) + 99'(s4_dt[1]) + 99'(s4_dt[2]);
      s5_acc <= 99'(s4_at[0]) + 99'(s4_at[1]) + 99'(s4_at[2]);

      s6_row  <= s5_row;
      s6_sing <= s5_det == '0;
      s6_den  <= det_abs[DEN_W-1:0];
      for (int c = 0; c < 3; c++) begin
        s6_num[c] <= NUM_W'(adj_abs[c]) << (2 * FRAC_BITS);
        s6_neg[c] <= s5_adjr[c][63] ^ s5_det[98];
      end
      s6_num[3] <= NUM_W'(acc_abs[DEN_W-1:0]) << FRAC_BITS;
      s6_neg[3] <= !s5_acc[98] ^ s5_det[98];

      trow[0] <= s6_row;
      tsg[0]  <= s6_sing;
      for (int i = 1; i < DIV_LAT; i++) begin
        trow[i] <= trow[i-1];
        tsg[i]  <= tsg[i-1];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    affinv_div #(
      .NUM_W (NUM_W),
      .DW    (DEN_W)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .num_mag (s6_num[g]),
      .num_neg (s6_neg[g]),
      .den_mag (s6_den),
      .quo     (quo[g])
    );
  end

  assign row_index = trow[DIV_LAT-1];
  assign singular  = tsg[DIV_LAT-1];
  assign last_row  = trow[DIV_LAT-1] == ROW_LAST;
  assign col0      = singular ? '0 : quo[0];
  assign col1      = singular ? '0 : quo[1];
  assign col2      = singular ? '0 : quo[2];
  assign col3      = singular ? '0 : quo[3];
endmodule
